>>> rtl/stbst_pkg.sv
// Shared types and constants for the stall threshold binary search tuner.
`default_nettype none

package stbst_pkg;

    localparam int CfgAddrWidth = 3;
    localparam int CfgDataWidth = 32;

    // Configuration register indexes.
    localparam logic [CfgAddrWidth-1:0] CFG_SETUP_POSITION    = 3'd0;
    localparam logic [CfgAddrWidth-1:0] CFG_MAX_TRAVEL_STEPS  = 3'd1;
    localparam logic [CfgAddrWidth-1:0] CFG_FALSE_STALL_STEPS = 3'd2;
    localparam logic [CfgAddrWidth-1:0] CFG_SETTLE_MS         = 3'd3;
    localparam logic [CfgAddrWidth-1:0] CFG_PAUSE_MS          = 3'd4;
    localparam logic [CfgAddrWidth-1:0] CFG_SAFETY_MARGIN     = 3'd5;

    // Search range and threshold ceiling.
    localparam logic [8:0] SEARCH_LOW  = 9'd1;
    localparam logic [8:0] SEARCH_HIGH = 9'd254;
    localparam logic [8:0] THRESH_MAX  = 9'd255;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_POLL  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SETUP    = 3'd1,
        PH_SETTLE   = 3'd2,
        PH_ATTEMPT  = 3'd3,
        PH_BACKOFF  = 3'd4,
        PH_PAUSE    = 3'd5,
        PH_COMPLETE = 3'd6,
        PH_ERROR    = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_MOVE      = 2'd1,
        CMD_HOMING    = 2'd2,
        CMD_STOP_MOVE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] setup_position;
        logic [30:0]        max_travel_steps;
        logic [30:0]        false_stall_steps;
        logic [15:0]        settle_ms;
        logic [15:0]        pause_ms;
        logic [7:0]         safety_margin;
    } cfg_t;

    typedef struct packed {
        logic               func;
        logic [31:0]        now_ms;
        logic signed [31:0] motor_position;
        logic               motor_moving;
        logic               motor_stalled;
    } item_t;

    typedef struct packed {
        cmd_t               command;
        logic signed [31:0] target_position;
        logic [7:0]         trial_threshold;
        phase_t             phase;
        logic [7:0]         recommended;
        logic               recommended_valid;
        logic [3:0]         attempt_count;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/stbst_cfg_regs.sv
// Configuration register bank written through the plain write port.
`default_nettype none

module stbst_cfg_regs
    import stbst_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [CfgAddrWidth-1:0] cfg_addr,
    input  wire logic [CfgDataWidth-1:0] cfg_wdata,
    output cfg_t                         cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SETUP_POSITION:    cfg_reg.setup_position    <= cfg_wdata;
                CFG_MAX_TRAVEL_STEPS:  cfg_reg.max_travel_steps  <= cfg_wdata[30:0];
                CFG_FALSE_STALL_STEPS: cfg_reg.false_stall_steps <= cfg_wdata[30:0];
                CFG_SETTLE_MS:         cfg_reg.settle_ms         <= cfg_wdata[15:0];
                CFG_PAUSE_MS:          cfg_reg.pause_ms          <= cfg_wdata[15:0];
                CFG_SAFETY_MARGIN:     cfg_reg.safety_margin     <= cfg_wdata[7:0];
                // Other addresses, such as the homing speed, are ignored.
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/stbst_seq.sv
// Phase sequencer and search state: one item is stepped per enabled cycle.
`default_nettype none

module stbst_seq
    import stbst_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  step_en,
    input  wire item_t item,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [31:0] phase_start_reg, phase_start_next;
    logic [8:0]  low_bound_reg, low_bound_next;
    logic [8:0]  high_bound_reg, high_bound_next;
    logic [7:0]  midpoint_reg, midpoint_next;
    logic [7:0]  best_reg, best_next;
    logic        best_valid_reg, best_valid_next;
    logic [3:0]  attempts_reg, attempts_next;
    logic [31:0] att_start_reg, att_start_next;

    logic [31:0] elapsed;
    logic [9:0]  bound_sum;
    logic [7:0]  mid_calc;
    logic [3:0]  att_inc;
    logic [32:0] pos_diff;
    logic [32:0] travel_wide;
    logic [31:0] travel;
    logic        travel_limit;
    logic        false_stall;
    logic [8:0]  rec_sum;
    cmd_t        cmd;
    logic [31:0] target;
    logic [7:0]  trial;

    assign elapsed   = item.now_ms - phase_start_reg;
    assign bound_sum = {1'b0, low_bound_reg} + {1'b0, high_bound_reg};
    assign mid_calc  = bound_sum[8:1];
    assign att_inc   = (attempts_reg == 4'hF) ? attempts_reg : attempts_reg + 4'd1;

    // Travel is the exact distance from the attempt start, up to 2^32-1.
    assign pos_diff     = {item.motor_position[31], item.motor_position}
                        - {att_start_reg[31], att_start_reg};
    assign travel_wide  = pos_diff[32] ? (33'd0 - pos_diff) : pos_diff;
    assign travel       = travel_wide[31:0];
    assign travel_limit = travel >= {1'b0, cfg.max_travel_steps};
    assign false_stall  = travel <= {1'b0, cfg.false_stall_steps};

    always_comb begin
        phase_next       = phase_reg;
        phase_start_next = phase_start_reg;
        low_bound_next   = low_bound_reg;
        high_bound_next  = high_bound_reg;
        midpoint_next    = midpoint_reg;
        best_next        = best_reg;
        best_valid_next  = best_valid_reg;
        attempts_next    = attempts_reg;
        att_start_next   = att_start_reg;
        cmd              = CMD_NONE;
        target           = '0;
        trial            = '0;

        if (item.func == FUNC_START) begin
            low_bound_next   = SEARCH_LOW;
            high_bound_next  = SEARCH_HIGH;
            best_valid_next  = 1'b0;
            best_next        = '0;
            attempts_next    = '0;
            cmd              = CMD_MOVE;
            target           = cfg.setup_position;
            phase_next       = PH_SETUP;
            phase_start_next = item.now_ms;
        end else begin
            case (phase_reg)
                PH_SETUP: begin
                    if (!item.motor_moving) begin
                        cmd              = CMD_HOMING;
                        trial            = mid_calc;
                        att_start_next   = item.motor_position;
                        midpoint_next    = mid_calc;
                        attempts_next    = att_inc;
                        phase_next       = PH_SETTLE;
                        phase_start_next = item.now_ms;
                    end
                end
                PH_SETTLE: begin
                    if (elapsed >= {16'd0, cfg.settle_ms}) begin
                        phase_next       = PH_ATTEMPT;
                        phase_start_next = item.now_ms;
                    end
                end
                PH_ATTEMPT: begin
                    if (item.motor_stalled || travel_limit) begin
                        if (!item.motor_stalled) begin
                            low_bound_next = {1'b0, midpoint_reg} + 9'd1;
                        end else if (false_stall) begin
                            high_bound_next = {1'b0, midpoint_reg} - 9'd1;
                        end else begin
                            best_next       = midpoint_reg;
                            best_valid_next = 1'b1;
                            high_bound_next = {1'b0, midpoint_reg} - 9'd1;
                        end
                        cmd              = CMD_STOP_MOVE;
                        target           = att_start_reg;
                        phase_next       = PH_BACKOFF;
                        phase_start_next = item.now_ms;
                    end
                end
                PH_BACKOFF: begin
                    if (!item.motor_moving) begin
                        phase_next       = PH_PAUSE;
                        phase_start_next = item.now_ms;
                    end
                end
                PH_PAUSE: begin
                    if (elapsed >= {16'd0, cfg.pause_ms}) begin
                        if (low_bound_reg > high_bound_reg) begin
                            phase_next       = best_valid_reg ? PH_COMPLETE : PH_ERROR;
                            phase_start_next = item.now_ms;
                        end else begin
                            cmd              = CMD_HOMING;
                            trial            = mid_calc;
                            att_start_next   = item.motor_position;
                            midpoint_next    = mid_calc;
                            attempts_next    = att_inc;
                            phase_next       = PH_SETTLE;
                            phase_start_next = item.now_ms;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            phase_start_reg <= '0;
            low_bound_reg   <= SEARCH_LOW;
            high_bound_reg  <= SEARCH_HIGH;
            midpoint_reg    <= '0;
            best_reg        <= '0;
            best_valid_reg  <= 1'b0;
            attempts_reg    <= '0;
            att_start_reg   <= '0;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            phase_start_reg <= phase_start_next;
            low_bound_reg   <= low_bound_next;
            high_bound_reg  <= high_bound_next;
            midpoint_reg    <= midpoint_next;
            best_reg        <= best_next;
            best_valid_reg  <= best_valid_next;
            attempts_reg    <= attempts_next;
            att_start_reg   <= att_start_next;
        end
    end

    assign rec_sum = {1'b0, best_next} + {1'b0, cfg.safety_margin};

    always_comb begin
        res.command           = cmd;
        res.target_position   = target;
        res.trial_threshold   = trial;
        res.phase             = phase_next;
        res.recommended_valid = best_valid_next;
        res.attempt_count     = attempts_next;
        if (!best_valid_next) begin
            res.recommended = '0;
        end else if (rec_sum > THRESH_MAX) begin
            res.recommended = THRESH_MAX[7:0];
        end else begin
            res.recommended = rec_sum[7:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/stall_threshold_binary_search_tuner.sv
// Stall threshold tuner top level: input register, sequencer, result register.
//
// The host writes the configuration registers through cfg_we/cfg_addr/cfg_wdata
// while the tuner is idle. It then sends a start item (s_tuser = 0) followed by
// poll items (s_tuser = 1) carrying the time, motor position and motor flags.
// Every item produces exactly one result item on the m_ channel: the motor
// command to issue (m_tuser), its target or trial threshold, the phase after
// the item, the recommendation and the attempt count.
// An accepted item is held in the input register until it is stepped; the
// sequencer then updates its search state and loads the result register at
// the same edge.
// One item is taken per cycle while results drain; the sequencer computes
// the new phase and bounds combinationally, which allows that rate.
// When the receiver holds m_tready low the result register keeps its item and
// the input register fills; s_tready falls only when both are occupied.
// Reset (aresetn low, synchronous) empties both registers, clears the
// configuration to zero and returns the sequencer to idle with bounds 1..254.
`default_nettype none

module stall_threshold_binary_search_tuner
    import stbst_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [CfgAddrWidth-1:0] cfg_addr,
    input  wire logic [CfgDataWidth-1:0] cfg_wdata,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // [31:0] now_ms, [63:32] motor_position, [64] motor_moving,
    // [65] motor_stalled, [71:66] zero
    input  wire logic [71:0]             s_tdata,
    // [0] func
    input  wire logic                    s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [31:0] target_position, [39:32] trial_threshold, [42:40] phase,
    // [50:43] recommended, [51] recommended_valid, [55:52] attempt_count
    output logic [55:0]                  m_tdata,
    // [1:0] command
    output logic [1:0]                   m_tuser
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t step_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    step_en;

    stbst_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held item is stepped whenever the result register is free or draining.
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.func           <= s_tuser;
            in_item_reg.now_ms         <= s_tdata[31:0];
            in_item_reg.motor_position <= s_tdata[63:32];
            in_item_reg.motor_moving   <= s_tdata[64];
            in_item_reg.motor_stalled  <= s_tdata[65];
        end
    end

    stbst_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (step_en),
        .item    (in_item_reg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.command;
    assign m_tdata  = {out_res_reg.attempt_count,
                       out_res_reg.recommended_valid,
                       out_res_reg.recommended,
                       out_res_reg.phase,
                       out_res_reg.trial_threshold,
                       out_res_reg.target_position};

`ifndef SYNTHESIS
    // A trial threshold is always inside the search range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.command == CMD_HOMING)
        |-> (out_res_reg.trial_threshold != 8'd0 && out_res_reg.trial_threshold != 8'd255))
        else $error("trial threshold outside search range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_res_reg.recommended_valid)
        |-> (out_res_reg.recommended == 8'd0))
        else $error("recommendation given without a real stall");

    // A stop-and-return command always leaves the sequencer backing off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.command == CMD_STOP_MOVE)
        |-> (out_res_reg.phase == PH_BACKOFF))
        else $error("stop command outside back-off");

    // A held item that cannot be stepped is not dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step_en) |=> in_valid_reg)
        else $error("input item lost while result stalled");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the stall threshold binary search tuner.
`timescale 1ns / 1ps

module tb;
    import stbst_pkg::*;

    localparam logic [CfgAddrWidth-1:0] CfgTestSpeed = 3'd6;
    localparam int unsigned CycleLimit = 400_000;
    localparam int unsigned HoldCycles = 300;
    localparam int RandomPhases = 5;
    localparam int ItemsPerPhase = 280;
    localparam longint PosMax = 64'sd2147483647;
    localparam longint PosMin = -64'sd2147483648;

    // Tracks the sequencer state of the tuner and holds the results it should produce.
    class tuning_scoreboard;
        cfg_t               regs;
        phase_t             phase;
        logic [31:0]        phase_since;
        logic [8:0]         lo_bound;
        logic [8:0]         hi_bound;
        logic [7:0]         trial;
        logic [7:0]         best;
        logic               best_ok;
        logic [3:0]         tries;
        logic signed [31:0] start_pos;
        result_t            pending_results[$];
        int                 errors;

        function new();
            regs = '0;
            phase = PH_IDLE;
            phase_since = '0;
            lo_bound = SEARCH_LOW;
            hi_bound = SEARCH_HIGH;
            trial = '0;
            best = '0;
            best_ok = 1'b0;
            tries = '0;
            start_pos = '0;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void set_reg(logic [CfgAddrWidth-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_SETUP_POSITION:    regs.setup_position = data;
                CFG_MAX_TRAVEL_STEPS:  regs.max_travel_steps = data[30:0];
                CFG_FALSE_STALL_STEPS: regs.false_stall_steps = data[30:0];
                CFG_SETTLE_MS:         regs.settle_ms = data[15:0];
                CFG_PAUSE_MS:          regs.pause_ms = data[15:0];
                CFG_SAFETY_MARGIN:     regs.safety_margin = data[7:0];
                default: ;
            endcase
        endfunction

        function void enter(phase_t p, logic [31:0] now);
            phase = p;
            phase_since = now;
        endfunction

        function logic [7:0] begin_attempt(logic signed [31:0] pos, logic [31:0] now);
            logic [9:0] sum;
            start_pos = pos;
            sum = {1'b0, lo_bound} + {1'b0, hi_bound};
            trial = sum[8:1];
            if (tries < 4'd15) tries = tries + 4'd1;
            enter(PH_SETTLE, now);
            return trial;
        endfunction

        function void note_item(item_t it);
            logic [31:0] elapsed;
            longint      travel;
            logic [8:0]  rec;
            result_t     r;
            elapsed = it.now_ms - phase_since;
            r = '0;
            if (it.func == FUNC_START) begin
                lo_bound = SEARCH_LOW;
                hi_bound = SEARCH_HIGH;
                best_ok = 1'b0;
                best = '0;
                tries = '0;
                r.command = CMD_MOVE;
                r.target_position = regs.setup_position;
                enter(PH_SETUP, it.now_ms);
            end else begin
                case (phase)
                    PH_SETUP: begin
                        if (!it.motor_moving) begin
                            r.command = CMD_HOMING;
                            r.trial_threshold = begin_attempt(it.motor_position, it.now_ms);
                        end
                    end
                    PH_SETTLE: begin
                        if (elapsed >= 32'(regs.settle_ms)) enter(PH_ATTEMPT, it.now_ms);
                    end
                    PH_ATTEMPT: begin
                        travel = longint'(it.motor_position) - longint'(start_pos);
                        if (travel < 0) travel = -travel;
                        if (it.motor_stalled || travel >= longint'(regs.max_travel_steps)) begin
                            if (!it.motor_stalled) begin
                                lo_bound = 9'(trial) + 9'd1;
                            end else if (travel <= longint'(regs.false_stall_steps)) begin
                                hi_bound = 9'(trial) - 9'd1;
                            end else begin
                                best = trial;
                                best_ok = 1'b1;
                                hi_bound = 9'(trial) - 9'd1;
                            end
                            r.command = CMD_STOP_MOVE;
                            r.target_position = start_pos;
                            enter(PH_BACKOFF, it.now_ms);
                        end
                    end
                    PH_BACKOFF: begin
                        if (!it.motor_moving) enter(PH_PAUSE, it.now_ms);
                    end
                    PH_PAUSE: begin
                        if (elapsed >= 32'(regs.pause_ms)) begin
                            if (lo_bound > hi_bound) begin
                                enter(best_ok ? PH_COMPLETE : PH_ERROR, it.now_ms);
                            end else begin
                                r.command = CMD_HOMING;
                                r.trial_threshold = begin_attempt(it.motor_position, it.now_ms);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            r.phase = phase;
            if (best_ok) begin
                rec = 9'(best) + 9'(regs.safety_margin);
                r.recommended = (rec > THRESH_MAX) ? 8'(THRESH_MAX) : rec[7:0];
            end
            r.recommended_valid = best_ok;
            r.attempt_count = tries;
            pending_results.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected, command %0d", got.command);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare("command", 32'(want.command), 32'(got.command));
            compare("target_position", 32'(want.target_position), 32'(got.target_position));
            compare("trial_threshold", 32'(want.trial_threshold), 32'(got.trial_threshold));
            compare("phase", 32'(want.phase), 32'(got.phase));
            compare("recommended", 32'(want.recommended), 32'(got.recommended));
            compare("recommended_valid", 32'(want.recommended_valid),
                    32'(got.recommended_valid));
            compare("attempt_count", 32'(want.attempt_count), 32'(got.attempt_count));
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CfgAddrWidth-1:0] cfg_addr = '0;
    logic [CfgDataWidth-1:0] cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [71:0]             s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [55:0]             m_tdata;
    logic [1:0]              m_tuser;

    tuning_scoreboard sb = new();
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    logic [31:0] sim_ms = '0;

    stall_threshold_binary_search_tuner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("** stall_threshold_binary_search_tuner: FAILED **");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HoldCycles;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.command = cmd_t'(m_tuser);
            got.target_position = m_tdata[31:0];
            got.trial_threshold = m_tdata[39:32];
            got.phase = phase_t'(m_tdata[42:40]);
            got.recommended = m_tdata[50:43];
            got.recommended_valid = m_tdata[51];
            got.attempt_count = m_tdata[55:52];
            sb.check_result(got);
        end
    end

    function automatic item_t mk(logic func, logic [31:0] now, logic [31:0] pos,
                                 logic moving, logic stalled);
        item_t it;
        it.func = func;
        it.now_ms = now;
        it.motor_position = pos;
        it.motor_moving = moving;
        it.motor_stalled = stalled;
        return it;
    endfunction

    // A position at the given distance from base, on whichever side stays in range.
    function automatic logic [31:0] offset_pos(logic signed [31:0] base, longint span);
        longint up;
        longint dn;
        up = longint'(base) + span;
        dn = longint'(base) - span;
        if (up > PosMax || ($urandom_range(1) == 0 && dn >= PosMin)) return dn[31:0];
        return up[31:0];
    endfunction

    // Mostly well-formed polls that follow the sequencer, with some noise and restarts.
    function automatic item_t next_item();
        item_t       it;
        int unsigned step_max;
        int unsigned pick;
        longint      span;
        longint      max_t;
        longint      false_t;
        step_max = 2 * ((sb.regs.settle_ms > sb.regs.pause_ms) ?
                        sb.regs.settle_ms : sb.regs.pause_ms) + 2;
        if ($urandom_range(99) < 5) sim_ms = $urandom();
        else sim_ms = sim_ms + $urandom_range(step_max, 0);
        it = mk(FUNC_POLL, sim_ms, $urandom(), $urandom_range(99) < 40,
                $urandom_range(99) < 30);
        pick = $urandom_range(99);
        if (pick < 2) begin
            it.func = FUNC_START;
        end else if (pick >= 6) begin
            case (sb.phase)
                PH_IDLE, PH_COMPLETE, PH_ERROR: begin
                    if ($urandom_range(99) < 80) it.func = FUNC_START;
                end
                PH_ATTEMPT: begin
                    max_t = longint'(sb.regs.max_travel_steps);
                    false_t = longint'(sb.regs.false_stall_steps);
                    pick = $urandom_range(99);
                    if (pick < 40) begin
                        it.motor_stalled = 1'b0;
                        span = (max_t == 0) ? 0 : longint'($urandom_range(32'(max_t - 1), 0));
                    end else if (pick < 65) begin
                        it.motor_stalled = 1'b1;
                        span = longint'($urandom_range(32'(false_t), 0));
                    end else if (pick < 90) begin
                        it.motor_stalled = 1'b1;
                        span = false_t + 1 + longint'($urandom_range(1000));
                    end else begin
                        it.motor_stalled = 1'b0;
                        span = max_t + longint'($urandom_range(1000));
                    end
                    if (span > PosMax) span = PosMax;
                    // The last few keep a fully random position for very long travel.
                    if ($urandom_range(99) < 93) it.motor_position = offset_pos(sb.start_pos, span);
                end
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        if (!calm && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (!calm && $urandom_range(99) < 27);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, it.motor_stalled, it.motor_moving, it.motor_position, it.now_ms};
        s_tuser <= it.func;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
    endtask

    task automatic wait_results_in();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all registers in a row; unused high bits of the write data carry noise.
    task automatic load_settings(input cfg_t c, input logic [15:0] speed);
        logic [31:0]             vals [7];
        int                      widths [7];
        logic [CfgAddrWidth-1:0] idx [7];
        logic [31:0]             mask;
        logic [31:0]             data;
        vals = '{c.setup_position, 32'(c.max_travel_steps), 32'(c.false_stall_steps),
                 32'(c.settle_ms), 32'(c.pause_ms), 32'(c.safety_margin), 32'(speed)};
        widths = '{32, 31, 31, 16, 16, 8, 16};
        idx = '{CFG_SETUP_POSITION, CFG_MAX_TRAVEL_STEPS, CFG_FALSE_STALL_STEPS,
                CFG_SETTLE_MS, CFG_PAUSE_MS, CFG_SAFETY_MARGIN, CfgTestSpeed};
        for (int i = 0; i < 7; i++) begin
            mask = (widths[i] == 32) ? 32'hFFFF_FFFF : ((32'd1 << widths[i]) - 32'd1);
            data = (vals[i] & mask) | ($urandom() & ~mask);
            cfg_we <= 1'b1;
            cfg_addr <= idx[i];
            cfg_wdata <= data;
            @(posedge aclk);
            sb.set_reg(idx[i], data);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        cfg_t        s;
        logic [15:0] speed;
        int unsigned mx;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        s = {32'h8000_0000, 31'd100, 31'd10, 16'd3, 16'd2, 8'd255};
        speed = 16'hFFFF;
        load_settings(s, speed);

        // Directed walk through one run, with the time stamp wrapping early on.
        send_item(mk(FUNC_POLL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1));
        send_item(mk(FUNC_START, 32'hFFFF_FFF0, 32'h8000_0000, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'hFFFF_FFF1, 32'h0000_0000, 1'b1, 1'b0));
        send_item(mk(FUNC_POLL, 32'hFFFF_FFF2, 32'h7FFF_FF00, 1'b0, 1'b1));
        send_item(mk(FUNC_POLL, 32'hFFFF_FFF3, 32'h0000_0000, 1'b0, 1'b1));
        send_item(mk(FUNC_POLL, 32'd1, 32'h0000_0000, 1'b1, 1'b0));
        send_item(mk(FUNC_POLL, 32'd2, 32'h7FFF_FF63, 1'b1, 1'b0));
        send_item(mk(FUNC_POLL, 32'd3, 32'h7FFF_FEF6, 1'b1, 1'b1));
        send_item(mk(FUNC_POLL, 32'd4, 32'h0000_0000, 1'b1, 1'b1));
        send_item(mk(FUNC_POLL, 32'd5, 32'h0000_0000, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'd6, 32'h0000_0000, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'd7, 32'hFFFF_FC18, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'd10, 32'h0000_0000, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'd11, 32'hFFFF_FC23, 1'b0, 1'b1));
        send_item(mk(FUNC_POLL, 32'd12, 32'h0000_0000, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'd14, 32'h7FFF_FFFF, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'd17, 32'h0000_0000, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'd18, 32'h8000_0000, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'd19, 32'h0000_0000, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'd21, 32'h0000_0000, 1'b0, 1'b0));
        send_item(mk(FUNC_START, 32'd22, 32'h0000_0000, 1'b0, 1'b0));
        send_item(mk(FUNC_POLL, 32'd23, 32'h0000_0000, 1'b0, 1'b0));

        sim_ms = $urandom();
        for (int k = 0; k < RandomPhases; k++) begin
            wait_results_in();
            case (k)
                0: begin
                    s = '0;
                    speed = '0;
                end
                1: begin
                    s = {32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF,
                         8'hFF};
                    speed = 16'hFFFF;
                end
                default: begin
                    mx = $urandom_range(3000, 1);
                    s = {32'($urandom()), 31'(mx), 31'($urandom_range(mx, 0)),
                         16'($urandom_range(40)), 16'($urandom_range(40)), 8'($urandom())};
                    speed = 16'($urandom());
                end
            endcase
            load_settings(s, speed);
            for (int n = 0; n < ItemsPerPhase; n++) begin
                if (k == 2 && n == 100) hold_req <= 1'b1;
                if (k == 3 && n == 40) calm <= 1'b1;
                if (k == 3 && n == 200) calm <= 1'b0;
                if (k == 4 && n == 140) wait_results_in();
                send_item(next_item());
            end
        end

        wait_results_in();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** stall_threshold_binary_search_tuner: PASSED **");
        end else begin
            $display("** stall_threshold_binary_search_tuner: FAILED **");
        end
        $finish;
    end

endmodule
